// ===== hdl/tcce_pkg.sv =====
// shared types and constants for the text console cursor engine
// screen geometry, character codes, request codes and payload structs
// no dependencies
package tcce_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int ADDR_W  = $clog2(CELLS);
	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int POS_W   = 11;
	// wide enough for any row * COLUMNS + col in the allowed geometry
	localparam int LIN_W   = 13;

	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_RETURN  = 8'd13;
	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] RESET_ATTR = 8'h07;
	localparam logic [7:0] TAB_MASK   = 8'hfc;
	localparam logic [7:0] TAB_STEP   = 8'd4;

	typedef enum logic [1:0] {
		REQ_PUT        = 2'd0,
		REQ_SET_CURSOR = 2'd1,
		REQ_CLEAR      = 2'd2,
		REQ_READ       = 2'd3
	} req_type_t;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [7:0]       char_code;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} req_t;

	typedef struct packed {
		logic [COL_W-1:0] cursor_col;
		logic [ROW_W-1:0] cursor_row;
		logic [POS_W-1:0] cursor_pos;
		logic [7:0]       cell_char;
		logic [7:0]       cell_attr;
	} rsp_t;

endpackage

// ===== hdl/text_console_cursor_engine.sv =====
// text console cursor engine: screen memory, cursor and request sequencer
// uses tcce_pkg for geometry, codes and payload structs
//
// Usage:
//   req channel (req_valid / req_stall / req) carries one request per transfer:
//   put character, set cursor, clear screen or read cell. rsp channel
//   (rsp_valid / rsp_stall / rsp) returns exactly one result per request with
//   the cursor after it, plus the cell contents for a read.
//   cfg_we / cfg_wdata write the attribute used for new and blanked cells.
//   Requests are handled one at a time; req_stall is high while one is busy.
//   Work per request, accept to result shown:
//     set cursor, return, newline move the cursor; put character writes a cell, read cell reads one
//     tab writes spaces up to the next tab stop (1 to 4 spaces)
//     any line feed off the bottom row also blanks a row of COLUMNS cells
//     clear screen blanks all CELLS cells
//   The screen memory has one port, and blanking walks it one cell a cycle.
//   Scrolling rotates a top-row pointer, so no cells are copied.
//   After reset the block sweeps all CELLS (2000) cells to blanks with
//   attribute 0x07 and holds req_stall high until that pass ends.
//   The result sits in an output register; a stalled result holds, and a
//   finished request waits for that register before taking the next one.
module text_console_cursor_engine
	import tcce_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_t       rsp,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	typedef enum logic [6:0] {
		S_INIT   = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_PUT    = 7'b0000100,
		S_SCROLL = 7'b0001000,
		S_CLEAR  = 7'b0010000,
		S_READ   = 7'b0100000,
		S_FIN    = 7'b1000000
	} state_t;

	localparam logic [COL_W-1:0]  COL_MAX   = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_MAX   = ROW_W'(ROWS - 1);
	localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] COL_LAST  = ADDR_W'(COLUMNS - 1);

	state_t            state_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  line_q;
	logic [ROW_W-1:0]  top_q;
	logic [7:0]        attr_q;
	logic [1:0]        op_q;
	logic [7:0]        ch_q;
	logic [COL_W-1:0]  rc_q;
	logic [ROW_W-1:0]  rr_q;
	logic [7:0]        stop_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [15:0]       mem [CELLS];
	logic [15:0]       rdata_q;
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_addr;
	logic [15:0]       mem_wdata;

	logic [COL_W-1:0]  c_cl;
	logic [ROW_W-1:0]  r_cl;
	logic [COL_W-1:0]  sel_col;
	logic [ROW_W-1:0]  sel_row;
	logic [ROW_W-1:0]  ofs;
	logic [ROW_W:0]    phys_sum;
	logic [ROW_W-1:0]  phys;
	logic [LIN_W-1:0]  lin;
	logic [7:0]        col_inc;
	logic [7:0]        wr_char;
	logic              accept;
	logic              out_free;
	logic              is_tab;

	assign accept    = (state_q == S_IDLE) && req_valid;
	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign c_cl    = (req.col > COL_MAX) ? COL_MAX : req.col;
	assign r_cl    = (req.row > ROW_MAX) ? ROW_MAX : req.row;
	assign is_tab  = (ch_q == CH_TAB);
	assign col_inc = 8'(col_q) + 8'd1;
	assign wr_char = is_tab ? CH_SPACE : ch_q;

	// shared address unit: row * COLUMNS + col; row rotated by top except for rsp cursor_pos
	always_comb begin
		sel_col = col_q;
		sel_row = line_q;
		ofs     = top_q;
		if (state_q == S_READ) begin
			sel_col = rc_q;
			sel_row = rr_q;
		end
		if (state_q == S_FIN) begin
			ofs = '0;
		end
		phys_sum = {1'b0, sel_row} + {1'b0, ofs};
		phys     = (phys_sum >= (ROW_W + 1)'(ROWS)) ?
			ROW_W'(phys_sum - (ROW_W + 1)'(ROWS)) : ROW_W'(phys_sum);
		if (state_q == S_SCROLL) begin
			phys    = top_q;
			sel_col = COL_W'(cnt_q);
		end
		lin = LIN_W'(phys) * LIN_W'(COLUMNS) + LIN_W'(sel_col);
	end

	always_comb begin
		mem_addr  = ADDR_W'(lin);
		mem_we    = 1'b0;
		mem_re    = (state_q == S_READ);
		mem_wdata = {attr_q, CH_SPACE};
		case (state_q)
			S_INIT: begin
				mem_addr  = cnt_q;
				mem_we    = 1'b1;
				mem_wdata = {RESET_ATTR, CH_SPACE};
			end
			S_CLEAR: begin
				mem_addr = cnt_q;
				mem_we   = 1'b1;
			end
			S_SCROLL: begin
				mem_we = 1'b1;
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_wdata = {attr_q, wr_char};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.req_type;
			ch_q   <= req.char_code;
			rc_q   <= c_cl;
			rr_q   <= r_cl;
			stop_q <= (8'(col_q) + TAB_STEP) & TAB_MASK;
		end
		if (state_q == S_FIN && out_free) begin
			rsp_q.cursor_col <= col_q;
			rsp_q.cursor_row <= line_q;
			rsp_q.cursor_pos <= POS_W'(lin);
			rsp_q.cell_char  <= (op_q == REQ_READ) ? rdata_q[7:0] : 8'd0;
			rsp_q.cell_attr  <= (op_q == REQ_READ) ? rdata_q[15:8] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cnt_q       <= '0;
			col_q       <= '0;
			line_q      <= '0;
			top_q       <= '0;
			attr_q      <= RESET_ATTR;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CELL_LAST) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						cnt_q <= '0;
						case (req.req_type)
							REQ_PUT: begin
								if (req.char_code == CH_NEWLINE) begin
									col_q <= '0;
									if (line_q == ROW_MAX) begin
										state_q <= S_SCROLL;
									end else begin
										line_q  <= line_q + 1'b1;
										state_q <= S_FIN;
									end
								end else if (req.char_code == CH_RETURN) begin
									col_q   <= '0;
									state_q <= S_FIN;
								end else begin
									state_q <= S_PUT;
								end
							end
							REQ_SET_CURSOR: begin
								col_q   <= c_cl;
								line_q  <= r_cl;
								state_q <= S_FIN;
							end
							REQ_CLEAR: begin
								state_q <= S_CLEAR;
							end
							REQ_READ: begin
								state_q <= S_READ;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_PUT: begin
					if (col_inc == 8'(COLUMNS)) begin
						// wrapped at line end, a tab ends here too
						col_q <= '0;
						if (line_q == ROW_MAX) begin
							state_q <= S_SCROLL;
						end else begin
							line_q  <= line_q + 1'b1;
							state_q <= S_FIN;
						end
					end else begin
						col_q <= COL_W'(col_inc);
						if (!(is_tab && col_inc < stop_q)) begin
							state_q <= S_FIN;
						end
					end
				end
				S_SCROLL: begin
					// blank the old top row, it becomes the new bottom row
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == COL_LAST) begin
						top_q   <= (top_q == ROW_MAX) ? '0 : top_q + 1'b1;
						state_q <= S_FIN;
					end
				end
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CELL_LAST) begin
						top_q   <= '0;
						col_q   <= '0;
						line_q  <= '0;
						state_q <= S_FIN;
					end
				end
				S_READ: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
